@@ src/haptic_report_scheduler_macros.svh @@
// ----------------------------------------------------------------------------
// Haptic report scheduler assertion macros
// Shared property forms for the checker of the report scheduler.
// ----------------------------------------------------------------------------
`ifndef HAPTIC_REPORT_SCHEDULER_MACROS_SVH
`define HAPTIC_REPORT_SCHEDULER_MACROS_SVH

// Same-cycle implication, off during reset
`define HRS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("haptic report scheduler: property violated");

// Next-cycle implication, off during reset
`define HRS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("haptic report scheduler: property violated");

`endif

@@ src/hrs_pkg.sv @@
// ----------------------------------------------------------------------------
// hrs_pkg
// Types, constants and report byte lookup for the haptic report scheduler.
// ----------------------------------------------------------------------------
package hrs_pkg;

  localparam int unsigned IDX_W       = 6;
  localparam int unsigned FIFO_DEPTH  = 2;
  localparam logic [15:0] INTERVAL_RST = 16'd500;

  localparam logic [7:0] HDR_ID      = 8'h02;
  localparam logic [7:0] HDR_FLAGS   = 8'h0f;
  localparam logic [7:0] BLK_ON_TAG  = 8'h21;
  localparam logic [7:0] BLK_OFF_TAG = 8'h05;

  localparam logic [IDX_W-1:0] VIB_AT0   = 6'd3;
  localparam logic [IDX_W-1:0] VIB_AT1   = 6'd4;
  localparam logic [IDX_W-1:0] ACCEL_AT  = 6'd11;
  localparam logic [IDX_W-1:0] BRAKE_AT  = 6'd22;
  localparam logic [IDX_W-1:0] BLK_BYTES = 6'd7;

  // Zone strengths, zone z at bits [4z +: 4]
  localparam logic [39:0] ACCEL_ZONES = {4'd5, 4'd5, 4'd4, 4'd4, 4'd3,
                                         4'd3, 4'd2, 4'd2, 4'd1, 4'd0};
  localparam logic [39:0] BRAKE_ZONES = {4'd8, 4'd8, 4'd8, 4'd7, 4'd6,
                                         4'd5, 4'd4, 4'd3, 4'd2, 4'd0};

  typedef enum logic [2:0] {
    KIND_CONNECT = 3'd0,
    KIND_PROFILE = 3'd1,
    KIND_RUMBLE  = 3'd2,
    KIND_TICK    = 3'd3,
    KIND_CLOSE   = 3'd4
  } kind_e;

  // One queued report request
  typedef struct packed {
    logic       feedback;
    logic [7:0] vib;
  } cmd_t;

  // Build the seven bytes of an active trigger block, byte 0 in [7:0]
  function automatic logic [55:0] build_block(input logic [39:0] zones);
    logic [9:0]  mask;
    logic [31:0] packed_s;
    logic [3:0]  zs;
    mask     = '0;
    packed_s = '0;
    for (int z = 0; z < 10; z++) begin
      zs = zones[4*z +: 4];
      if (zs != 4'd0) begin
        mask[z] = 1'b1;
        packed_s = packed_s | (32'(3'(zs - 4'd1)) << (3 * z));
      end
    end
    return {packed_s, 6'd0, mask[9:8], mask[7:0], BLK_ON_TAG};
  endfunction

  localparam logic [55:0] ACCEL_BLK = build_block(ACCEL_ZONES);
  localparam logic [55:0] BRAKE_BLK = build_block(BRAKE_ZONES);

  // Value of one report byte
  function automatic logic [7:0] report_byte_at(input logic [IDX_W-1:0] idx,
                                                input cmd_t cmd);
    logic [IDX_W-1:0] off;
    logic [7:0]       val;
    val = 8'h00;
    off = '0;
    if (idx == 6'd0) begin
      val = HDR_ID;
    end else if (idx == 6'd1) begin
      val = HDR_FLAGS;
    end else if (idx == VIB_AT0 || idx == VIB_AT1) begin
      val = cmd.vib;
    end else if (idx >= ACCEL_AT && idx < ACCEL_AT + BLK_BYTES) begin
      off = idx - ACCEL_AT;
      if (cmd.feedback) val = ACCEL_BLK[8*off[2:0] +: 8];
      else if (off == '0) val = BLK_OFF_TAG;
    end else if (idx >= BRAKE_AT && idx < BRAKE_AT + BLK_BYTES) begin
      off = idx - BRAKE_AT;
      if (cmd.feedback) val = BRAKE_BLK[8*off[2:0] +: 8];
      else if (off == '0) val = BLK_OFF_TAG;
    end
    return val;
  endfunction

endpackage

@@ src/hrs_front.sv @@
// ----------------------------------------------------------------------------
// hrs_front
// Event front end: holds feedback state, applies events and queues reports.
// ----------------------------------------------------------------------------
module hrs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [15:0]   refresh_interval_ms_i,
  input  logic          ev_valid_i,
  input  logic [2:0]    kind_i,
  input  logic          profile_on_i,
  input  logic [7:0]    rumble_strength_i,
  input  logic [15:0]   duration_ms_i,
  output logic          push_o,
  output hrs_pkg::cmd_t cmd_o
);
  import hrs_pkg::*;

  logic [15:0] interval_q, interval_d;
  logic        connected_q, connected_d;
  logic        profile_q, profile_d;
  logic [7:0]  level_q, level_d;
  logic [15:0] left_q, left_d;
  logic [15:0] since_q, since_d;

  logic [15:0] left_dec;
  logic [15:0] since_inc;
  logic [7:0]  level_tick;

  assign left_dec   = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;
  assign since_inc  = (since_q != 16'hffff) ? since_q + 16'd1 : since_q;
  assign level_tick = (level_q != 8'd0 && left_dec == 16'd0) ? 8'd0 : level_q;

  // Decode the event and apply it
  always_comb begin
    interval_d  = cfg_valid_i ? refresh_interval_ms_i : interval_q;
    connected_d = connected_q;
    profile_d   = profile_q;
    level_d     = level_q;
    left_d      = left_q;
    since_d     = since_q;
    push_o      = 1'b0;
    cmd_o       = '0;
    if (ev_valid_i) begin
      unique case (kind_i)
        KIND_CONNECT: begin
          connected_d = 1'b1;
          since_d     = '0;
          push_o      = 1'b1;
        end
        KIND_PROFILE: begin
          if (connected_q && profile_q != profile_on_i) begin
            profile_d    = profile_on_i;
            since_d      = '0;
            push_o       = 1'b1;
            cmd_o.feedback = profile_on_i;
            cmd_o.vib    = level_q;
          end
        end
        KIND_RUMBLE: begin
          if (connected_q) begin
            level_d      = rumble_strength_i;
            left_d       = duration_ms_i;
            since_d      = '0;
            push_o       = 1'b1;
            cmd_o.feedback = profile_q;
            cmd_o.vib    = rumble_strength_i;
          end
        end
        KIND_TICK: begin
          left_d  = left_dec;
          since_d = since_inc;
          if (connected_q) begin
            level_d = level_tick;
            if ((profile_q || level_tick != 8'd0) && since_inc >= interval_q) begin
              since_d        = '0;
              push_o         = 1'b1;
              cmd_o.feedback = profile_q;
              cmd_o.vib      = level_tick;
            end
          end
        end
        KIND_CLOSE: begin
          if (connected_q) begin
            connected_d = 1'b0;
            push_o      = 1'b1;
          end
        end
        default: begin
          // drop unknown events
        end
      endcase
    end
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= INTERVAL_RST;
      connected_q <= 1'b0;
      profile_q   <= 1'b0;
      level_q     <= '0;
      left_q      <= '0;
      since_q     <= '0;
    end else begin
      interval_q  <= interval_d;
      connected_q <= connected_d;
      profile_q   <= profile_d;
      level_q     <= level_d;
      left_q      <= left_d;
      since_q     <= since_d;
    end
  end

endmodule

@@ src/hrs_fifo.sv @@
// ----------------------------------------------------------------------------
// hrs_fifo
// Short queue of report requests between the front end and the serializer.
// ----------------------------------------------------------------------------
module hrs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hrs_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output hrs_pkg::cmd_t cmd_o
);
  import hrs_pkg::*;

  localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(FIFO_DEPTH);

  cmd_t             mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d;
  logic [PTR_W-1:0] rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == DEPTH_C);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Advance pointers and count
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == LAST_PTR) ? '0 : wptr_q + PTR_W'(1);
    if (do_pop)  rptr_d = (rptr_q == LAST_PTR) ? '0 : rptr_q + PTR_W'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + CNT_W'(1);
    else if (!do_push && do_pop) cnt_d = cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= cmd_i;
  end

endmodule

@@ src/hrs_back.sv @@
// ----------------------------------------------------------------------------
// hrs_back
// Report serializer: walks one queued request out as report byte beats.
// ----------------------------------------------------------------------------
module hrs_back #(
  parameter int unsigned REPORT_BYTES = 48
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmd_valid_i,
  input  hrs_pkg::cmd_t              cmd_i,
  output logic                       pop_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [hrs_pkg::IDX_W-1:0]  byte_index_o,
  output logic [7:0]                 report_byte_o,
  output logic                       last_byte_o
);
  import hrs_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPORT_BYTES - 1);

  logic             busy_q, busy_d;
  cmd_t             cmd_q, cmd_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic             ovalid_q, ovalid_d;
  logic [IDX_W-1:0] oidx_q, oidx_d;
  logic [7:0]       obyte_q, obyte_d;
  logic             olast_q, olast_d;
  logic             out_free;
  logic             at_last;

  assign out_free = !ovalid_q || !out_stall_i;
  assign at_last  = (cnt_q == LAST_IDX);
  // Take the next request when idle or as the current one finishes
  assign pop_o    = cmd_valid_i && (!busy_q || (out_free && at_last));

  always_comb begin
    busy_d   = busy_q;
    cmd_d    = cmd_q;
    cnt_d    = cnt_q;
    ovalid_d = ovalid_q && out_stall_i;
    oidx_d   = oidx_q;
    obyte_d  = obyte_q;
    olast_d  = olast_q;
    // Emit one beat into the output register
    if (busy_q && out_free) begin
      ovalid_d = 1'b1;
      oidx_d   = cnt_q;
      obyte_d  = report_byte_at(cnt_q, cmd_q);
      olast_d  = at_last;
      cnt_d    = cnt_q + IDX_W'(1);
      if (at_last) busy_d = 1'b0;
    end
    if (pop_o) begin
      busy_d = 1'b1;
      cmd_d  = cmd_i;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      busy_q   <= busy_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    oidx_q  <= oidx_d;
    obyte_q <= obyte_d;
    olast_q <= olast_d;
  end

  assign out_valid_o   = ovalid_q;
  assign byte_index_o  = oidx_q;
  assign report_byte_o = obyte_q;
  assign last_byte_o   = olast_q;

endmodule

@@ src/haptic_report_scheduler.sv @@
// ----------------------------------------------------------------------------
// haptic_report_scheduler
// Tracks controller feedback state and sends output reports byte by byte.
// ----------------------------------------------------------------------------
// Each accepted event updates the front-end state when it is taken; an event
// that calls for a report queues a request in a two-entry queue, and the
// serializer sends it as REPORT_BYTES beats, one per cycle while the output
// is not stalled; queued reports follow with no gap. Input events are taken
// every cycle until the queue holds two requests behind the report in
// flight, and the serializer then sets the sustained rate of reports.
// The refresh interval register resets to 500 ms and its port is always ready.
module haptic_report_scheduler #(
  parameter int unsigned REPORT_BYTES = 48
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] refresh_interval_ms_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic        profile_on_i,
  input  logic [7:0]  rumble_strength_i,
  input  logic [15:0] duration_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  byte_index_o,
  output logic [7:0]  report_byte_o,
  output logic        last_byte_o
);
  import hrs_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic q_valid;
  cmd_t q_cmd;
  logic pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full;

  hrs_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_valid_i           (cfg_valid_i),
    .refresh_interval_ms_i (refresh_interval_ms_i),
    .ev_valid_i            (in_valid_i && !q_full),
    .kind_i                (kind_i),
    .profile_on_i          (profile_on_i),
    .rumble_strength_i     (rumble_strength_i),
    .duration_ms_i         (duration_ms_i),
    .push_o                (push),
    .cmd_o                 (push_cmd)
  );

  hrs_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  hrs_back #(
    .REPORT_BYTES (REPORT_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (q_cmd),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .byte_index_o  (byte_index_o),
    .report_byte_o (report_byte_o),
    .last_byte_o   (last_byte_o)
  );

endmodule

@@ src/hrs_checker.sv @@
// ----------------------------------------------------------------------------
// hrs_checker
// Port-level checks on the report stream of the haptic report scheduler.
// ----------------------------------------------------------------------------
`include "haptic_report_scheduler_macros.svh"

module hrs_checker #(
  parameter int unsigned REPORT_BYTES = 48
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [5:0] byte_index_o,
  input logic [7:0] report_byte_o,
  input logic       last_byte_o
);
  import hrs_pkg::*;

  localparam logic [5:0] LAST_IDX = 6'(REPORT_BYTES - 1);

  // Stalled beat holds
  `HRS_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(byte_index_o) && $stable(report_byte_o))

  // Bytes of one report go out without gaps and in order
  `HRS_ASSERT_NXT(a_report_runs, clk_i, rst_ni, out_valid_o && !out_stall_i && !last_byte_o, out_valid_o && byte_index_o == $past(byte_index_o) + 6'd1)

  // Last marker sits on the final byte position only
  `HRS_ASSERT_IMP(a_last_pos, clk_i, rst_ni, out_valid_o, last_byte_o == (byte_index_o == LAST_IDX))

  // Every report opens with its header byte
  `HRS_ASSERT_IMP(a_header, clk_i, rst_ni, out_valid_o && byte_index_o == 6'd0, report_byte_o == HDR_ID)

endmodule

bind haptic_report_scheduler hrs_checker #(
  .REPORT_BYTES (REPORT_BYTES)
) u_hrs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .byte_index_o  (byte_index_o),
  .report_byte_o (report_byte_o),
  .last_byte_o   (last_byte_o)
);
